@@ hw/rtl/advs_pkg.sv @@
// ----------------------------------------------------------------------------
// advs_pkg: shared types and constants for the advection stencil step
// Method codes, register indexes, datapath widths and the sequencer states.
// ----------------------------------------------------------------------------
package advs_pkg;

	// grid value width (signed Q16.16)
	localparam int DATA_W = 32;
	// courant register width (unsigned Q1.16)
	localparam int COUR_W = 17;
	// datapath width holding every intermediate exactly
	localparam int ACC_W  = 38;
	// product width: datapath times zero-extended courant
	localparam int PROD_W = ACC_W + COUR_W + 1;

	// configuration register indexes
	localparam logic REG_METHOD  = 1'b0;
	localparam logic REG_COURANT = 1'b1;

	// reset value of the courant register (0.5)
	localparam logic [COUR_W-1:0] COURANT_RESET = 17'd32768;

	// update methods
	typedef enum logic [1:0] {
		METH_UPWIND = 2'd0,
		METH_LAXF   = 2'd1,
		METH_LAXW   = 2'd2,
		METH_NONE   = 2'd3
	} method_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL1 = 6'b000010,
		ST_MUL2 = 6'b000100,
		ST_DIFF = 6'b001000,
		ST_MUL3 = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

endpackage

@@ hw/rtl/advection_stencil_step.sv @@
// ----------------------------------------------------------------------------
// advection_stencil_step: one time step of 1-D periodic linear advection
// Streams grid cells in, releases upwind, Lax-Friedrichs or Lax-Wendroff
// updates (zeros for method 3) through one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Cells arrive as signed Q16.16 words on the s_ side, s_tlast closing the
// frame; each word from the third on releases the update of the cell before
// it, and the last word also releases the final cell and cell 0. All products
// go through one registered multiplier (datapath times the 17-bit courant
// number), so each update runs the method's multiply chain: an input word
// is taken in the idle state, then upwind and Lax-Friedrichs run one
// multiply and one finish step, Lax-Wendroff three multiplies, one
// difference and one finish step, and method 3 the finish step alone. The
// last word adds two more updates; cells 0 and 1 only fill the history. A
// frame of fewer than three cells gives one error word. The result sits in
// an output register; the sequencer waits at its finish step only while
// that register is still full. Configuration writes are always taken
// (cfg_ready high).
module advection_stencil_step
	import advs_pkg::*;
#(
	parameter int MAX_CELLS  = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [COUR_W-1:0]     cfg_data,
	// input cells
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_W-1:0]     s_tdata,   // [31:0] cell_value
	input  logic                  s_tlast,   // last_cell
	// results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] new_value, then cell_index, then zero padding
	output logic [((DATA_W+$clog2(MAX_CELLS)+7)/8)*8-1:0] m_tdata,
	output logic                  m_tlast,   // last_result
	output logic                  m_tuser    // [0] frame_error
);

	localparam int IDX_W   = $clog2(MAX_CELLS);
	localparam int TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;
	localparam int PAD_W   = TDATA_W - DATA_W - IDX_W;
	localparam int SAT_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	localparam logic signed [ACC_W-1:0] SAT_HI =
		ACC_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
	localparam logic [IDX_W:0]   POS_LIMIT = (IDX_W+1)'(MAX_CELLS);
	localparam logic [IDX_W-1:0] POS_MAX   = IDX_W'(MAX_CELLS - 1);

	// configuration registers
	method_t             method_q;
	logic [COUR_W-1:0]   courant_q;

	// stencil history
	logic [DATA_W-1:0]   first_q, second_q, older_q, newer_q;
	logic [IDX_W-1:0]    position_q;

	// sequencer
	state_t              state_q;
	logic [1:0]          job_q;
	logic [1:0]          job_last_q;
	logic                err_q;
	logic [IDX_W-1:0]    pos_q;

	// operands of the current update and intermediates
	logic [DATA_W-1:0]   l_q, u_q, r_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  hr_q, hd_q;

	// output register
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_value_q;
	logic [IDX_W-1:0]    out_index_q;
	logic                out_last_q;
	logic                out_err_q;

	logic                in_fire, cfg_fire, out_free;

	logic signed [ACC_W-1:0] l_x, u_x, r_x;
	logic signed [ACC_W-1:0] sum_ur, sum_ul, sum_lr;
	logic signed [ACC_W-1:0] half_ur, half_ul, half_lr;
	logic signed [ACC_W-1:0] p16, p17, hl;
	logic signed [ACC_W-1:0] mul_a;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ACC_W-1:0] v_raw, v_sat;
	state_t                  start_st;
	logic [IDX_W:0]          pos_inc;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_index_q, out_value_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	// operand extension and half sums (floor halving)
	assign l_x = {{(ACC_W-DATA_W){l_q[DATA_W-1]}}, l_q};
	assign u_x = {{(ACC_W-DATA_W){u_q[DATA_W-1]}}, u_q};
	assign r_x = {{(ACC_W-DATA_W){r_q[DATA_W-1]}}, r_q};
	assign sum_ur  = u_x + r_x;
	assign sum_ul  = u_x + l_x;
	assign sum_lr  = l_x + r_x;
	assign half_ur = {sum_ur[ACC_W-1], sum_ur[ACC_W-1:1]};
	assign half_ul = {sum_ul[ACC_W-1], sum_ul[ACC_W-1:1]};
	assign half_lr = {sum_lr[ACC_W-1], sum_lr[ACC_W-1:1]};

	// product scaled down by 2^16 and 2^17, flooring
	assign p16 = prod_q[16 +: ACC_W];
	assign p17 = prod_q[17 +: ACC_W];
	assign hl  = half_ul - p17;

	// shared multiplier operand select
	always_comb begin
		mul_a = hd_q;
		case (state_q)
			ST_MUL1: begin
				case (method_q)
					METH_LAXF: mul_a = l_x - r_x;
					METH_LAXW: mul_a = r_x - u_x;
					default:   mul_a = l_x - u_x;
				endcase
			end
			ST_MUL2: mul_a = u_x - l_x;
			default: mul_a = hd_q;
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, courant_q});

	// final combine and saturation
	always_comb begin
		case (method_q)
			METH_UPWIND: v_raw = u_x + p16;
			METH_LAXF:   v_raw = half_lr + p17;
			METH_LAXW:   v_raw = u_x + p16;
			default:     v_raw = '0;
		endcase
		if (v_raw > SAT_HI) begin
			v_sat = SAT_HI;
		end else if (v_raw < SAT_LO) begin
			v_sat = SAT_LO;
		end else begin
			v_sat = v_raw;
		end
	end

	assign start_st = (method_q == METH_NONE) ? ST_FIN : ST_MUL1;
	assign pos_inc  = {1'b0, position_q} + 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q  <= METH_UPWIND;
			courant_q <= COURANT_RESET;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_METHOD:  method_q  <= method_t'(cfg_data[1:0]);
				REG_COURANT: courant_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and stencil history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			position_q <= '0;
			first_q    <= '0;
			second_q   <= '0;
			older_q    <= '0;
			newer_q    <= '0;
			job_q      <= '0;
			job_last_q <= '0;
			err_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						job_q <= '0;
						pos_q <= position_q;
						if (position_q < IDX_W'(2)) begin
							if (s_tlast) begin
								// short frame: one error word, restart
								err_q      <= 1'b1;
								job_last_q <= '0;
								position_q <= '0;
								state_q    <= ST_FIN;
							end else begin
								if (position_q == '0) begin
									first_q <= s_tdata;
								end else begin
									second_q <= s_tdata;
								end
								older_q    <= newer_q;
								newer_q    <= s_tdata;
								position_q <= pos_inc[IDX_W-1:0];
							end
						end else begin
							// update of the previous cell
							err_q      <= 1'b0;
							l_q        <= older_q;
							u_q        <= newer_q;
							r_q        <= s_tdata;
							older_q    <= newer_q;
							newer_q    <= s_tdata;
							job_last_q <= s_tlast ? 2'd2 : 2'd0;
							if (s_tlast) begin
								position_q <= '0;
							end else if (pos_inc >= POS_LIMIT) begin
								position_q <= POS_MAX;
							end else begin
								position_q <= pos_inc[IDX_W-1:0];
							end
							state_q <= start_st;
						end
					end
				end
				ST_MUL1: begin
					prod_q  <= mul_p;
					state_q <= (method_q == METH_LAXW) ? ST_MUL2 : ST_FIN;
				end
				ST_MUL2: begin
					hr_q    <= half_ur - p17;
					prod_q  <= mul_p;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					hd_q    <= hl - hr_q;
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					prod_q  <= mul_p;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						if (job_q != job_last_q) begin
							// wrap-around updates of the closing cells
							job_q <= job_q + 2'd1;
							if (job_q == 2'd0) begin
								l_q <= older_q;
								u_q <= newer_q;
								r_q <= first_q;
							end else begin
								l_q <= newer_q;
								u_q <= first_q;
								r_q <= second_q;
							end
							state_q <= start_st;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_err_q <= err_q;
			if (err_q) begin
				out_value_q <= '0;
				out_index_q <= '0;
				out_last_q  <= 1'b1;
			end else begin
				out_value_q <= v_sat[DATA_W-1:0];
				case (job_q)
					2'd0:    out_index_q <= pos_q - 1'b1;
					2'd1:    out_index_q <= pos_q;
					default: out_index_q <= '0;
				endcase
				out_last_q <= (job_q == 2'd2);
			end
		end
	end

endmodule
